// ===== src/adagrad_element_update_defines.svh =====
// Assertion macros shared by the checker.
`ifndef ADAGRAD_ELEMENT_UPDATE_DEFINES_SVH
`define ADAGRAD_ELEMENT_UPDATE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define AEU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define AEU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/aeu_pkg.sv =====
// ---------------------------------------------------------------------------
// aeu_pkg
// Widths, constants and types for the element-wise Adagrad update.
// ---------------------------------------------------------------------------
package aeu_pkg;
  localparam int unsigned GradW  = 32;
  localparam int unsigned StateW = 64;
  localparam int unsigned SqW    = 63;
  localparam int unsigned LrW    = 32;
  localparam int unsigned RootW  = 32;
  localparam int unsigned DenW   = 33;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned PaddrW = 1;
  localparam logic [LrW-1:0] LrReset = 32'd1677722;
  localparam logic [PaddrW-1:0] RegLearningRate = 1'b0;
  // Cells in the root chain, then cells in the divide chain.
  localparam int unsigned RootCells = 32;
  localparam int unsigned DivCells  = 64;

  // Input item: one gradient element and its accumulated state.
  typedef struct packed {
    logic signed [GradW-1:0] gradient;
    logic [StateW-1:0]       old_state;
  } grad_item_t;

  // Result item.
  typedef struct packed {
    logic [SqW-1:0]          squared_gradient;
    logic [StateW-1:0]       new_state;
    logic signed [GradW-1:0] step;
    logic                    saturated;
  } update_t;

  // Data that travels down the row of cells.
  typedef struct packed {
    logic              neg;
    logic              sat;
    logic [SqW-1:0]    sq;
    logic [StateW-1:0] ns;
    logic [ProdW-1:0]  num;   // dividend, shifted in one bit per divide cell
    logic [ProdW-1:0]  quo;   // quotient bits so far
    logic [DenW:0]     rem;   // running remainder
    logic [StateW-1:0] rrem;  // root remainder / radicand scratch
    logic [RootW-1:0]  root;  // root bits so far
    logic [StateW-1:0] rad;   // radicand bits not yet consumed
  } aeu_cell_t;
endpackage

// ===== src/aeu_stream_if.sv =====
// ---------------------------------------------------------------------------
// aeu_stream_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
interface aeu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/aeu_root_cell.sv =====
// ---------------------------------------------------------------------------
// aeu_root_cell
// One digit-recurrence step of the integer square root.
// ---------------------------------------------------------------------------
module aeu_root_cell import aeu_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  aeu_cell_t c_i,
  output aeu_cell_t c_o
);
  logic [StateW+1:0] trial;
  logic [StateW+1:0] rsh;
  aeu_cell_t         c_d;
  aeu_cell_t         c_q;

  always_comb begin
    c_d   = c_i;
    // Bring down two radicand bits; test (4*root+1).
    rsh   = {c_i.rrem, c_i.rad[StateW-1 -: 2]};
    trial = {{(StateW-RootW){1'b0}}, c_i.root, 2'b01};
    c_d.rad = {c_i.rad[StateW-3:0], 2'b00};
    if (rsh >= trial) begin
      c_d.rrem = StateW'(rsh - trial);
      c_d.root = {c_i.root[RootW-2:0], 1'b1};
    end else begin
      c_d.rrem = StateW'(rsh);
      c_d.root = {c_i.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end
  assign c_o = c_q;
endmodule

// ===== src/aeu_div_cell.sv =====
// ---------------------------------------------------------------------------
// aeu_div_cell
// One restoring-division step: one quotient bit per cell.
// ---------------------------------------------------------------------------
module aeu_div_cell import aeu_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  aeu_cell_t c_i,
  output aeu_cell_t c_o
);
  logic [DenW:0] rsh;
  logic [DenW:0] den;
  aeu_cell_t     c_d;
  aeu_cell_t     c_q;

  always_comb begin
    c_d = c_i;
    // Divisor is root + 1, formed from the finished root.
    den = {2'b00, c_i.root} + (DenW+1)'(1);
    rsh = {c_i.rem[DenW-1:0], c_i.num[ProdW-1]};
    c_d.num = {c_i.num[ProdW-2:0], 1'b0};
    if (rsh >= den) begin
      c_d.rem = rsh - den;
      c_d.quo = {c_i.quo[ProdW-2:0], 1'b1};
    end else begin
      c_d.rem = rsh;
      c_d.quo = {c_i.quo[ProdW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q <= c_d;
    end
  end
  assign c_o = c_q;
endmodule

// ===== src/adagrad_element_update.sv =====
// ---------------------------------------------------------------------------
// adagrad_element_update
// Fixed-point Adagrad step on one gradient element per item.
// ---------------------------------------------------------------------------
// Channel   Dir  Payload
// in_if     in   gradient (s32), old_state (u64)
// out_if    out  squared_gradient (u63), new_state (u64), step (s32), saturated
// apb       in   step size register (lr_q) at address 0
//
// One item is accepted per cycle unless the row is stalled. The pipeline is
// a square stage, a product stage, 32 root cells, 64 divide cells and an
// output stage. The whole row advances together; it stalls only when the
// output register holds an item that is not taken. Reset clears valid bits
// and sets the step size to about 0.1.
module adagrad_element_update import aeu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  aeu_stream_if.sink         in_if,
  aeu_stream_if.source       out_if
);
  localparam int unsigned Depth = 2 + RootCells + DivCells;

  logic [LrW-1:0] lr_q;
  logic [Depth-1:0] vld_q;
  logic adv;
  logic [GradW-1:0] gmag;
  logic gneg;
  logic [SqW:0] sqw;
  logic [StateW:0] sum;

  aeu_cell_t s0_d, s0_q, s1_d, s1_q;
  aeu_cell_t chain [RootCells+DivCells+1];
  aeu_cell_t fin;
  logic [ProdW-1:0] mag;
  logic [GradW-1:0] step;
  logic ssat;

  assign pready = 1'b1;
  assign prdata = (paddr == RegLearningRate) ? lr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q <= LrReset;
    end else if (psel && penable && pwrite && paddr == RegLearningRate) begin
      lr_q <= pwdata;
    end
  end

  // The row moves whenever the output register is free or being emptied.
  assign adv = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_if.valid};
    end
  end

  // Stage 0: magnitude, square, saturating state add.
  always_comb begin
    gneg = in_if.data.gradient[GradW-1];
    gmag = gneg ? GradW'(-in_if.data.gradient) : GradW'(in_if.data.gradient);
    sqw  = (SqW+1)'({32'd0, gmag} * {32'd0, gmag});
    sum  = {1'b0, in_if.data.old_state} + {2'b00, sqw[SqW-1:0]};
    s0_d = '0;
    s0_d.neg = gneg;
    s0_d.sq  = sqw[SqW-1:0];
    s0_d.sat = sum[StateW];
    s0_d.ns  = sum[StateW] ? '1 : sum[StateW-1:0];
    s0_d.rad = s0_d.ns;
    s0_d.num = {32'd0, gmag};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= s0_d;
      s1_q <= s1_d;
    end
  end

  // Stage 1: learning rate times magnitude.
  always_comb begin
    s1_d = s0_q;
    s1_d.num = ProdW'(lr_q) * s0_q.num[GradW-1:0];
  end

  assign chain[0] = s1_q;
  for (genvar i = 0; i < RootCells; i++) begin : g_root
    aeu_root_cell u_cell (.clk_i(clk_i), .en_i(adv), .c_i(chain[i]), .c_o(chain[i+1]));
  end
  for (genvar j = 0; j < DivCells; j++) begin : g_div
    aeu_div_cell u_cell (.clk_i(clk_i), .en_i(adv),
                         .c_i(chain[RootCells+j]), .c_o(chain[RootCells+j+1]));
  end
  assign fin = chain[RootCells+DivCells];

  always_comb begin
    mag = fin.quo;
    ssat = 1'b0;
    if (mag == '0) begin
      step = '0;
    end else if (fin.neg) begin
      if (mag > ProdW'(32'h7FFF_FFFF)) begin
        ssat = 1'b1;
        step = 32'h7FFF_FFFF;
      end else begin
        step = mag[GradW-1:0];
      end
    end else begin
      if (mag > ProdW'(33'h1_0000_0000) >> 1) begin
        ssat = 1'b1;
        step = 32'h8000_0000;
      end else begin
        step = GradW'(-mag[GradW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.valid <= 1'b0;
    end else if (adv) begin
      out_if.valid <= vld_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_if.data.squared_gradient <= fin.sq;
      out_if.data.new_state        <= fin.ns;
      out_if.data.step             <= step;
      out_if.data.saturated        <= fin.sat | ssat;
    end
  end
endmodule

// ===== src/aeu_checker.sv =====
// ---------------------------------------------------------------------------
// aeu_checker
// Port-level checks for the Adagrad update block.
// ---------------------------------------------------------------------------
`include "adagrad_element_update_defines.svh"
module aeu_checker import aeu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pready,
  input logic [31:0] step,
  input logic        saturated
);
  `AEU_ASSERT_IMP(a_pready, clk_i, rst_ni, 1'b1, pready)
  `AEU_ASSERT_IMP(a_flow, clk_i, rst_ni, out_ready, in_ready)
  `AEU_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)
  `AEU_ASSERT_NXT(a_stable, clk_i, rst_ni, out_valid && !out_ready,
                  $stable(step) && $stable(saturated))
endmodule

bind adagrad_element_update aeu_checker u_aeu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .pready(pready),
  .step(out_if.data.step), .saturated(out_if.data.saturated)
);
